// ===== hdl/oat_pkg.sv =====
// Shared types and constants for the ordered array table.
package oat_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 4;
  localparam int ST_W         = 2;
  localparam int IDX_OUT_W    = 4;
  localparam int LEN_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 48;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_SEARCH = 3'd2,
    OP_GET    = 3'd3,
    OP_UPDATE = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_MISS   = 2'd3
  } st_t;

  // per-cell control from the table front end
  typedef struct packed {
    logic wr;     // load the request value
    logic shift;  // take the left neighbor's entry
    logic live;   // entry lies below the fill count
  } cell_ctrl_t;

  // per-cell search result, rippled along the row
  typedef struct packed {
    logic any;    // this or an earlier cell matched
    logic first;  // this cell is the lowest match
  } cell_stat_t;

endpackage

// ===== hdl/oat_cell.sv =====
// One table cell: an entry register, neighbor shift and match compare.
module oat_cell import oat_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] left_data,
  input  logic              hit_in,
  output logic [DATA_W-1:0] data,
  output cell_stat_t        stat
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              match;

  always_comb begin
    if (ctrl.wr) begin
      data_nxt = value;
    end else if (ctrl.shift) begin
      data_nxt = left_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign match      = ctrl.live && (data_r == value);
  assign stat.first = match && !hit_in;
  assign stat.any   = match || hit_in;
  assign data       = data_r;

endmodule

// ===== hdl/ordered_array_table_top.sv =====
// Top level of the ordered array table: request decode, cell row and result register.
//
//  channel | dir | tdata fields (low bit up)                          | handshake
//  in_     | in  | operation[2:0] position[6:3] value[38:7]           | tvalid/tready
//  out_    | out | status[1:0] found_index[5:2] read_value[37:6]
//          |     |   length[42:38]                                    | tvalid/tready
//
// One request per cycle unless stalled; each result is registered in the next cycle.
// Append, insert, search, get and update all finish in the cell row in the request's cycle:
// cells shift and compare in parallel, the lowest match ripples along the row.
// rst_n (synchronous) clears the fill count and the result valid; entries are not cleared.
// A stalled result holds; a new request is taken whenever the result register is free
// or being taken in the same cycle.
module ordered_array_table_top import oat_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // operation, position, value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, found_index, read_value, length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = ($clog2(CAPACITY) > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int FW = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;

  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  op_t               in_op;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_value;
  logic              accept;
  logic [PW-1:0]     pos_ext, cnt_ext;
  logic              full;

  logic do_append, do_insert, do_update, grow;
  st_t               status;
  logic [FW-1:0]     fidx;
  logic [DATA_W-1:0] rval;
  logic [LW-1:0]     len_ext;

  cell_ctrl_t        ctrl [CAPACITY];
  cell_stat_t        stat [CAPACITY];
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0] hit_c;
  logic [IW-1:0]     first_idx;
  logic [DATA_W-1:0] sel_data;

  assign in_op    = op_t'(in_tdata[2:0]);
  assign in_pos   = in_tdata[6:3];
  assign in_value = in_tdata[38:7];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign pos_ext = PW'(in_pos);
  assign cnt_ext = PW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));

  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_update = 1'b0;
    status    = ST_OK;
    case (in_op)
      OP_APPEND: begin
        if (full) status = ST_FULL;
        else do_append = 1'b1;
      end
      OP_INSERT: begin
        if (full) status = ST_FULL;
        else if (pos_ext > cnt_ext) status = ST_BADPOS;
        else do_insert = 1'b1;
      end
      OP_SEARCH: begin
        if (!hit_c[CAPACITY]) status = ST_MISS;
      end
      OP_GET: begin
        if (pos_ext >= cnt_ext) status = ST_BADPOS;
      end
      OP_UPDATE: begin
        if (pos_ext >= cnt_ext) status = ST_BADPOS;
        else do_update = 1'b1;
      end
      default: begin
        status = ST_BADPOS;
      end
    endcase
  end

  assign grow = accept && (do_append || do_insert);

  // cell row
  assign hit_c[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [PW-1:0] IDX = PW'(g);

    assign ctrl[g].wr    = accept && ((do_append && (IDX == cnt_ext)) ||
                                      ((do_insert || do_update) && (IDX == pos_ext)));
    assign ctrl[g].shift = accept && do_insert && (IDX > pos_ext);
    assign ctrl[g].live  = IDX < cnt_ext;

    oat_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .value     (in_value),
      .left_data ((g == 0) ? in_value : cell_data[(g == 0) ? 0 : g - 1]),
      .hit_in    (hit_c[g]),
      .data      (cell_data[g]),
      .stat      (stat[g])
    );

    assign hit_c[g+1] = stat[g].any;
  end

  always_comb begin
    first_idx = '0;
    sel_data  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (stat[i].first) first_idx = first_idx | IW'(i);
      if (PW'(i) == pos_ext) sel_data = sel_data | cell_data[i];
    end
  end

  always_comb begin
    fidx = '0;
    rval = '0;
    if (in_op == OP_SEARCH && status == ST_OK) fidx = FW'(first_idx);
    if (in_op == OP_GET && status == ST_OK) rval = sel_data;
  end

  assign count_nxt = grow ? count_r + 1'b1 : count_r;
  assign len_ext   = LW'(count_nxt);

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'd0, len_ext[LEN_W-1:0], rval, fidx[IDX_OUT_W-1:0], status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/oat_chk.sv =====
// Port-level checker for the ordered array table, bound to the top level.
module oat_chk import oat_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("request gave no result");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("request stalled with free result slot");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_FULL) |-> out_tdata[42:38] == LEN_W'(CAPACITY))
    else $error("full status with wrong length");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> out_tdata[37:2] == '0)
    else $error("failed request carries nonzero index or data");

endmodule

bind ordered_array_table_top oat_chk #(.CAPACITY(CAPACITY)) u_oat_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
